// ----- rtl/ssod_pkg.sv -----
// Shared types, widths and codes for the distance switch block.
package ssod_pkg;

  localparam int COUNT_BITS_DEF = 16;

  localparam int DIST_W     = 20;  // distance in tenths
  localparam int DQ_W       = 17;  // distance in whole units
  localparam int HYST_W     = 16;
  localparam int THR_W      = 16;
  localparam int MODE_W     = 3;
  localparam int PER_W      = 10;
  localparam int DLY_W      = 16;
  localparam int STEP_W     = 4;
  localparam int ALU_MIN_W  = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int IN_TDATA_W = 40;
  localparam int OUT_TDATA_W = 8;

  localparam logic [PER_W-1:0] MS_PER_S = 10'd1000;

  // divide by ten as x * ceil(2^23 / 10) >> 23, exact for x below 2^22
  localparam int                RECIP_SH  = 23;
  localparam logic [DIST_W-1:0] RECIP_TEN = 20'd838861;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_TYPE   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORMALLY_OPEN = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COMPARE_MODE  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_ONE = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_TWO = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_MODE    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_MS     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_TIME    = 4'd7;

  // delay modes
  localparam logic [MODE_W-1:0] DLY_OFF    = 3'd0;
  localparam logic [MODE_W-1:0] DLY_ON     = 3'd1;
  localparam logic [MODE_W-1:0] DLY_OFFD   = 3'd2;
  localparam logic [MODE_W-1:0] DLY_ON_OFF = 3'd3;
  localparam logic [MODE_W-1:0] DLY_PULSE  = 3'd4;

  // output status codes
  localparam logic [1:0] ST_OFF      = 2'd0;
  localparam logic [1:0] ST_ON       = 2'd1;
  localparam logic [1:0] ST_INACTIVE = 2'd2;

  typedef struct packed {
    logic              output_type;
    logic              normally_open;
    logic              compare_mode;
    logic [THR_W-1:0]  threshold_one;
    logic [THR_W-1:0]  threshold_two;
    logic [MODE_W-1:0] delay_mode;
    logic [PER_W-1:0]  period_ms;
    logic [DLY_W-1:0]  delay_time;
  } cfg_t;

  // npn_level in bit 0
  typedef struct packed {
    logic       detect_state;
    logic [1:0] output_status;
    logic       pnp_level;
    logic       npn_level;
  } res_t;

endpackage

// ----- rtl/ssod_alu.sv -----
// Shared add/subtract unit used by the divide and multiply sequencer.
module ssod_alu #(
  parameter int W = 16
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] res,
  output logic         cout
);

  assign {cout, res} = {1'b0, a} + {1'b0, (sub ? ~b : b)} + (W+1)'(sub);

endmodule

// ----- rtl/ssod_seq.sv -----
// Sequencer: distance/10 by reciprocal multiply, 1000/period and delay limit on one shared adder.
module ssod_seq import ssod_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIST_W-1:0]     distance_tenths,
  input  logic [PER_W-1:0]      period_ms,
  input  logic [DLY_W-1:0]      delay_time,
  output logic                  done,
  output logic [DQ_W-1:0]       dist_units,
  output logic [COUNT_BITS-1:0] limit
);

  localparam int AW = (COUNT_BITS > ALU_MIN_W) ? COUNT_BITS : ALU_MIN_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DIV10 = 2'd1;
  localparam logic [1:0] S_DIVP  = 2'd2;
  localparam logic [1:0] S_MUL   = 2'd3;

  logic [1:0]        state;
  logic [STEP_W-1:0] step;
  logic [AW-1:0]     acc;
  logic [DIST_W-1:0] quo;
  logic [PER_W-1:0]  fac;

  logic [AW-1:0]       rem_sh;
  logic [AW-1:0]       alu_a;
  logic [AW-1:0]       alu_b;
  logic                alu_sub;
  logic [AW-1:0]       alu_res;
  logic                alu_cout;
  logic [AW-1:0]       div_acc_next;
  logic [DIST_W-1:0]   quo_next;
  logic [AW-1:0]       mul_acc_next;
  logic [2*DIST_W-1:0] recip_prod;

  // restoring divide: shift in next dividend bit, trial subtract
  // multiply: acc = 2*acc + (factor bit ? delay_time : 0), MSB first
  always_comb begin
    rem_sh  = {acc[AW-2:0], quo[DIST_W-1]};
    alu_sub = (state != S_MUL);
    if (state == S_MUL) begin
      alu_a = {acc[AW-2:0], 1'b0};
      alu_b = fac[PER_W-1] ? AW'(delay_time) : '0;
    end else begin
      alu_a = rem_sh;
      alu_b = AW'(period_ms);
    end
  end

  ssod_alu #(.W(AW)) u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .sub  (alu_sub),
    .res  (alu_res),
    .cout (alu_cout)
  );

  // no borrow (cout high) means the subtract fits
  assign div_acc_next = alu_cout ? alu_res : rem_sh;
  assign quo_next     = {quo[DIST_W-2:0], alu_cout};
  assign mul_acc_next = AW'(alu_res[COUNT_BITS-1:0]);

  // tenths to whole units, one constant multiply
  assign recip_prod = (2*DIST_W)'(quo) * (2*DIST_W)'(RECIP_TEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            quo   <= distance_tenths;
            acc   <= '0;
            step  <= '0;
            state <= S_DIV10;
          end
        end
        S_DIV10: begin
          dist_units <= recip_prod[RECIP_SH +: DQ_W];
          if (period_ms == '0) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            quo   <= {MS_PER_S, (DIST_W - PER_W)'(0)};
            state <= S_DIVP;
          end
        end
        S_DIVP: begin
          acc  <= div_acc_next;
          quo  <= quo_next;
          step <= step + 1'b1;
          if (step == STEP_W'(PER_W - 1)) begin
            fac   <= quo_next[PER_W-1:0];
            acc   <= '0;
            step  <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          acc  <= mul_acc_next;
          fac  <= {fac[PER_W-2:0], 1'b0};
          step <= step + 1'b1;
          if (step == STEP_W'(PER_W - 1)) begin
            limit <= mul_acc_next[COUNT_BITS-1:0];
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/ssod_eval.sv -----
// Comparator, output timing stage and pin drive state.
module ssod_eval import ssod_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  cfg_t                  cfg,
  input  logic [DQ_W-1:0]       dist_units,
  input  logic [HYST_W-1:0]     hyst,
  input  logic                  over,
  input  logic                  shorted,
  input  logic [COUNT_BITS-1:0] limit,
  output res_t                  res
);

  localparam int CW = DQ_W + 1;

  logic                  detect_flag;
  logic [1:0]            output_flag;
  logic [COUNT_BITS-1:0] delay_count;
  logic                  npn_pin;
  logic                  pnp_pin;

  logic                  detect_next;
  logic [1:0]            output_next;
  logic [COUNT_BITS-1:0] count_next;
  logic                  npn_next;
  logic                  pnp_next;

  logic [THR_W-1:0]      lo;
  logic [THR_W-1:0]      hi;
  logic [THR_W-1:0]      hi_sel;
  logic [CW-1:0]         dh;
  logic [CW-1:0]         hi_h;
  logic [CW-1:0]         lo_h;
  logic                  set_cond;
  logic                  clr_cond;
  logic                  differ;
  logic                  prev_on;
  logic                  on;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic                  expired;
  logic                  tick_cnt;

  // comparator; thresholds minus hysteresis moved to the distance side
  always_comb begin
    lo     = (cfg.threshold_one > cfg.threshold_two) ? cfg.threshold_two : cfg.threshold_one;
    hi     = (cfg.threshold_one > cfg.threshold_two) ? cfg.threshold_one : cfg.threshold_two;
    hi_sel = cfg.compare_mode ? hi : cfg.threshold_one;
    dh     = CW'(dist_units) + CW'(hyst);
    hi_h   = CW'(hi_sel) + CW'(hyst);
    lo_h   = CW'(lo) + CW'(hyst);
    set_cond = (dh < CW'(hi_sel)) && (!cfg.compare_mode || (CW'(dist_units) > lo_h));
    clr_cond = (CW'(dist_units) > hi_h) || (cfg.compare_mode && (dh < CW'(lo)));
    if (over) begin
      detect_next = 1'b0;
    end else if (detect_flag) begin
      detect_next = !clr_cond;
    end else begin
      detect_next = set_cond;
    end
  end

  // timing stage
  always_comb begin
    differ   = ({1'b0, detect_next} != output_flag);
    prev_on  = (output_flag != ST_OFF);
    on       = prev_on;
    cnt_inc  = delay_count + 1'b1;
    expired  = (cnt_inc >= limit);
    tick_cnt = 1'b0;
    count_next = delay_count;
    if (differ) begin
      case (cfg.delay_mode)
        DLY_OFF: on = detect_next;
        DLY_ON: begin
          if (detect_next) begin
            tick_cnt = 1'b1;
            if (expired) on = 1'b1;
          end else begin
            count_next = '0;
            on = 1'b0;
          end
        end
        DLY_OFFD: begin
          if (!detect_next) begin
            tick_cnt = 1'b1;
            if (expired) on = 1'b0;
          end else begin
            count_next = '0;
            on = 1'b1;
          end
        end
        DLY_ON_OFF: begin
          tick_cnt = 1'b1;
          if (expired) on = detect_next;
        end
        DLY_PULSE: begin
          if (prev_on) begin
            tick_cnt = 1'b1;
            if (expired) on = 1'b0;
          end else begin
            count_next = '0;
            on = detect_next;
          end
        end
        default: ;
      endcase
    end else begin
      count_next = '0;
    end
    if (tick_cnt) begin
      count_next = expired ? '0 : cnt_inc;
    end

    // unselected pin always cleared
    npn_next    = cfg.output_type ? 1'b0 : npn_pin;
    pnp_next    = cfg.output_type ? pnp_pin : 1'b0;
    output_next = output_flag;
    if (cfg.period_ms == '0) begin
      count_next = delay_count;
    end else if (shorted) begin
      output_next = ST_INACTIVE;
    end else if (on) begin
      if (output_flag != ST_ON) begin
        if (cfg.output_type) pnp_next = cfg.normally_open;
        else                 npn_next = cfg.normally_open;
        output_next = ST_ON;
      end
    end else begin
      if (output_flag != ST_OFF) begin
        if (cfg.output_type) pnp_next = !cfg.normally_open;
        else                 npn_next = !cfg.normally_open;
        output_next = ST_OFF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      detect_flag <= 1'b0;
      output_flag <= ST_OFF;
      delay_count <= '0;
      npn_pin     <= 1'b0;
      pnp_pin     <= 1'b0;
    end else if (step) begin
      detect_flag <= detect_next;
      output_flag <= output_next;
      delay_count <= count_next;
      npn_pin     <= npn_next;
      pnp_pin     <= pnp_next;
    end
  end

  assign res = '{detect_state: detect_flag, output_status: output_flag,
                 pnp_level: pnp_pin, npn_level: npn_pin};

endmodule

// ----- rtl/sensor_switch_output_with_delay.sv -----
// Top level of the distance switch: channels, configuration and sequencing.
//
// Usage notes:
// - Input stream (s_tvalid/s_tready/s_tdata) carries one distance request:
//   distance in tenths, hysteresis, over-range and short-circuit flags.
// - Output stream (m_tvalid/m_tready/m_tdata) returns one result per request:
//   NPN pin, PNP pin, output status and comparator state.
// - Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes one
//   register per handshake; cfg_ready is always high. Indexes 8..15 are ignored.
//   Write registers only while no request is in flight.
// - One request at a time: with a nonzero period a request passes the
//   divide-by-ten, 10 steps of 1000/period, 10 steps of the limit multiply,
//   evaluate and output load; period zero skips 1000/period and the multiply.
//   Divide-by-ten is a constant reciprocal multiply; the period divide and the
//   limit multiply share one adder in the sequencer; s_tready is low meanwhile.
// - Result sits in an output register, so a new request is taken while the
//   previous result still waits. If the receiver stalls with a result already
//   waiting, the next finished result holds until the register frees.
// - Reset (synchronous, active high) restores the default registers, clears
//   comparator, timing and pin state and drops m_tvalid.
module sensor_switch_output_with_delay import ssod_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // distance_tenths[19:0], hysteresis[35:20], over_range[36],
  // short_circuit[37], zero pad [39:38]
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // npn_level[0], pnp_level[1], output_status[3:2], detect_state[4], pad [7:5]
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_RUN  = 2'd1;
  localparam logic [1:0] T_HOLD = 2'd2;

  logic [1:0]            state;
  cfg_t                  cfg;
  logic [HYST_W-1:0]     hyst;
  logic                  over;
  logic                  shorted;
  logic                  start;
  logic                  seq_done;
  logic [DQ_W-1:0]       dist_units;
  logic [COUNT_BITS-1:0] limit;
  res_t                  res;
  logic                  out_load;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == T_IDLE);
  assign start     = s_tvalid && s_tready;
  assign out_load  = (state == T_HOLD) && (!m_tvalid || m_tready);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.output_type   <= 1'b0;
      cfg.normally_open <= 1'b1;
      cfg.compare_mode  <= 1'b0;
      cfg.threshold_one <= '0;
      cfg.threshold_two <= '0;
      cfg.delay_mode    <= DLY_OFF;
      cfg.period_ms     <= PER_W'(1);
      cfg.delay_time    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OUTPUT_TYPE:   cfg.output_type   <= cfg_data[0];
        REG_NORMALLY_OPEN: cfg.normally_open <= cfg_data[0];
        REG_COMPARE_MODE:  cfg.compare_mode  <= cfg_data[0];
        REG_THRESHOLD_ONE: cfg.threshold_one <= cfg_data[THR_W-1:0];
        REG_THRESHOLD_TWO: cfg.threshold_two <= cfg_data[THR_W-1:0];
        REG_DELAY_MODE:    cfg.delay_mode    <= cfg_data[MODE_W-1:0];
        REG_PERIOD_MS:     cfg.period_ms     <= cfg_data[PER_W-1:0];
        REG_DELAY_TIME:    cfg.delay_time    <= cfg_data[DLY_W-1:0];
        default: ;
      endcase
    end
  end

  // side fields held for the evaluate cycle
  always_ff @(posedge clk) begin
    if (start) begin
      hyst    <= s_tdata[DIST_W +: HYST_W];
      over    <= s_tdata[DIST_W + HYST_W];
      shorted <= s_tdata[DIST_W + HYST_W + 1];
    end
  end

  // request control and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= T_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        T_IDLE: if (start) state <= T_RUN;
        T_RUN:  if (seq_done) state <= T_HOLD;
        T_HOLD: if (out_load) state <= T_IDLE;
        default: state <= T_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= OUT_TDATA_W'(res);
    end
  end

  ssod_seq #(.COUNT_BITS(COUNT_BITS)) u_seq (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .distance_tenths (s_tdata[DIST_W-1:0]),
    .period_ms       (cfg.period_ms),
    .delay_time      (cfg.delay_time),
    .done            (seq_done),
    .dist_units      (dist_units),
    .limit           (limit)
  );

  ssod_eval #(.COUNT_BITS(COUNT_BITS)) u_eval (
    .clk        (clk),
    .rst        (rst),
    .step       (seq_done),
    .cfg        (cfg),
    .dist_units (dist_units),
    .hyst       (hyst),
    .over       (over),
    .shorted    (shorted),
    .limit      (limit),
    .res        (res)
  );

  // one request in flight: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while previous one still running");

  // no result shows both pins set; each step clears the unselected pin
  a_one_pin: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("both output pins set in a result");

  // over-range forces the comparator off
  a_over_off: assert property (@(posedge clk) disable iff (rst)
    (seq_done && over) |=> !res.detect_state)
    else $error("detect set after an over-range request");

endmodule

// ----- sim/sensor_switch_output_with_delay_tb.sv -----
// Self-checking stream testbench for the distance switch with output delay stage.
`timescale 1ns / 1ps

module sensor_switch_output_with_delay_tb;
  import ssod_pkg::*;

  localparam int CNT_W       = COUNT_BITS_DEF;
  localparam int MAX_TENTHS  = (1 << DIST_W) - 1;
  localparam int PHASES      = 27;
  localparam int PHASE_ITEMS = 50;
  localparam int SHOW_MAX    = 10;
  localparam logic [CFG_IDX_W-1:0] UNUSED_REG_BASE = REG_DELAY_TIME + 1'b1;

  // one distance request as it sits in s_tdata, lowest field last
  typedef struct packed {
    logic              short_circuit;
    logic              over_range;
    logic [HYST_W-1:0] hysteresis;
    logic [DIST_W-1:0] distance_tenths;
  } reading_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  sensor_switch_output_with_delay u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Shadow of the switch: register copy plus comparator, timing and pin state.
  cfg_t             sw_cfg;
  logic             det_q;
  logic [1:0]       out_q;
  logic [CNT_W-1:0] dly_cnt;
  logic             npn_q;
  logic             pnp_q;

  res_t pending_levels[$];  // predicted pin/status words, oldest first
  int   fail_count = 0;
  int   shown = 0;
  bit   fast_lane = 1'b0;   // both sides run without idle cycles
  int   rx_wait = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  // Hard stop well past the slowest legal run (~1400 requests).
  initial begin
    #(5_000_000);
    $display("sensor_switch_output_with_delay_tb NOT OK");
    $finish;
  end

  //--------------------------------------------------------------------------
  // Prediction
  //--------------------------------------------------------------------------

  // Counter steps up with wrap; reaching the limit clears it and reports expiry.
  function automatic logic delay_expired(input logic [CNT_W-1:0] limit);
    dly_cnt = dly_cnt + 1'b1;
    if (dly_cnt >= limit) begin
      dly_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void drive_pin(input logic level);
    if (!sw_cfg.output_type) npn_q = level;
    else pnp_q = level;
  endfunction

  function automatic void set_register(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_OUTPUT_TYPE:   sw_cfg.output_type = data[0];
      REG_NORMALLY_OPEN: sw_cfg.normally_open = data[0];
      REG_COMPARE_MODE:  sw_cfg.compare_mode = data[0];
      REG_THRESHOLD_ONE: sw_cfg.threshold_one = data[THR_W-1:0];
      REG_THRESHOLD_TWO: sw_cfg.threshold_two = data[THR_W-1:0];
      REG_DELAY_MODE:    sw_cfg.delay_mode = data[MODE_W-1:0];
      REG_PERIOD_MS:     sw_cfg.period_ms = data[PER_W-1:0];
      REG_DELAY_TIME:    sw_cfg.delay_time = data[DLY_W-1:0];
      default: ;
    endcase
  endfunction

  // One sensor tick: comparator, timing stage, pin drive.
  function automatic res_t switch_step(input reading_t s);
    int               dist_units, hyst, thr, lo, hi;
    int unsigned      factor;
    logic [31:0]      prod;
    logic [CNT_W-1:0] limit;
    logic             prev_on, on, det;
    res_t             r;
    dist_units = int'(s.distance_tenths / 10);  // truncate tenths to whole units
    hyst = int'(s.hysteresis);

    if (!sw_cfg.output_type) pnp_q = 1'b0;
    else npn_q = 1'b0;

    if (s.over_range) begin
      det_q = 1'b0;
    end else if (!sw_cfg.compare_mode) begin
      thr = int'(sw_cfg.threshold_one);
      if (!det_q) begin
        if (dist_units < thr - hyst) det_q = 1'b1;
      end else if (dist_units > thr + hyst) begin
        det_q = 1'b0;
      end
    end else begin
      lo = int'(sw_cfg.threshold_one);
      hi = int'(sw_cfg.threshold_two);
      if (lo > hi) begin
        thr = lo;
        lo = hi;
        hi = thr;
      end
      if (!det_q) begin
        if (dist_units < hi - hyst && dist_units > lo + hyst) det_q = 1'b1;
      end else if (dist_units > hi + hyst || dist_units < lo - hyst) begin
        det_q = 1'b0;
      end
    end

    // period zero freezes everything below
    if (sw_cfg.period_ms != '0) begin
      factor = 32'(MS_PER_S) / 32'(sw_cfg.period_ms);
      prod = sw_cfg.delay_time * factor;
      limit = prod[CNT_W-1:0];
      prev_on = (out_q != ST_OFF);  // inactive counts as on
      on = prev_on;
      det = det_q;
      if ({1'b0, det_q} != out_q) begin
        case (sw_cfg.delay_mode)
          DLY_OFF: on = det;
          DLY_ON: begin
            if (det) begin
              if (delay_expired(limit)) on = 1'b1;
            end else begin
              dly_cnt = '0;
              on = 1'b0;
            end
          end
          DLY_OFFD: begin
            if (!det) begin
              if (delay_expired(limit)) on = 1'b0;
            end else begin
              dly_cnt = '0;
              on = 1'b1;
            end
          end
          DLY_ON_OFF: begin
            if (delay_expired(limit)) on = det;
          end
          DLY_PULSE: begin
            if (prev_on) begin
              if (delay_expired(limit)) on = 1'b0;
            end else begin
              dly_cnt = '0;
              on = det;
            end
          end
          default: ;  // unused modes hold output and counter
        endcase
      end else begin
        dly_cnt = '0;
      end

      if (s.short_circuit) begin
        out_q = ST_INACTIVE;  // pins left as they are
      end else if (on) begin
        if (out_q != ST_ON) begin
          drive_pin(sw_cfg.normally_open);
          out_q = ST_ON;
        end
      end else if (out_q != ST_OFF) begin
        drive_pin(!sw_cfg.normally_open);
        out_q = ST_OFF;
      end
    end

    r.npn_level = npn_q;
    r.pnp_level = pnp_q;
    r.output_status = out_q;
    r.detect_state = det_q;
    return r;
  endfunction

  //--------------------------------------------------------------------------
  // Result side: random stall per result, compare against oldest prediction
  //--------------------------------------------------------------------------
  always @(posedge clk) begin
    res_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = res_t'(m_tdata[$bits(res_t)-1:0]);
        if (pending_levels.size() == 0) begin
          fail_count++;
          if (shown < SHOW_MAX) begin
            shown++;
            $display("unexpected result npn=%0d pnp=%0d status=%0d detect=%0d",
                     got.npn_level, got.pnp_level, got.output_status, got.detect_state);
          end
        end else begin
          want = pending_levels.pop_front();
          if (got !== want) begin
            fail_count++;
            if (shown < SHOW_MAX) begin
              shown++;
              $display("mismatch want npn=%0d pnp=%0d status=%0d detect=%0d",
                       want.npn_level, want.pnp_level, want.output_status,
                       want.detect_state);
              $display("         got  npn=%0d pnp=%0d status=%0d detect=%0d",
                       got.npn_level, got.pnp_level, got.output_status,
                       got.detect_state);
            end
          end
        end
        rx_wait = fast_lane ? 0 : $urandom_range(0, 8);
        m_tready <= (rx_wait == 0);
      end else if (!m_tready) begin
        if (rx_wait == 0) m_tready <= 1'b1;
        else rx_wait--;
      end
    end
  end

  //--------------------------------------------------------------------------
  // Request side and configuration
  //--------------------------------------------------------------------------

  // valid stays high across back-to-back requests; only dropped for a gap
  task automatic send_reading(input reading_t s);
    int gap;
    gap = fast_lane ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      if (s_tvalid) s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata <= IN_TDATA_W'(s);
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    pending_levels.push_back(switch_step(s));
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic drain_results();
    if (s_tvalid) s_tvalid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    set_register(idx, data);
  endtask

  // Full register load while the block is idle; optionally hit an unused index.
  task automatic configure(input cfg_t c, input bit poke_unused);
    drain_results();
    write_reg(REG_OUTPUT_TYPE, CFG_DATA_W'(c.output_type));
    write_reg(REG_NORMALLY_OPEN, CFG_DATA_W'(c.normally_open));
    write_reg(REG_COMPARE_MODE, CFG_DATA_W'(c.compare_mode));
    write_reg(REG_THRESHOLD_ONE, CFG_DATA_W'(c.threshold_one));
    write_reg(REG_THRESHOLD_TWO, CFG_DATA_W'(c.threshold_two));
    write_reg(REG_DELAY_MODE, CFG_DATA_W'(c.delay_mode));
    write_reg(REG_PERIOD_MS, CFG_DATA_W'(c.period_ms));
    write_reg(REG_DELAY_TIME, CFG_DATA_W'(c.delay_time));
    if (poke_unused)
      write_reg(CFG_IDX_W'(UNUSED_REG_BASE + $urandom_range(0, 7)), CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  function automatic reading_t reading(input int tenths, input int hyst,
                                       input bit over, input bit shorted);
    reading_t r;
    r.distance_tenths = DIST_W'(tenths);
    r.hysteresis = HYST_W'(hyst);
    r.over_range = over;
    r.short_circuit = shorted;
    return r;
  endfunction

  function automatic cfg_t plain_setup();
    cfg_t c;
    c.output_type = 1'b0;
    c.normally_open = 1'b1;
    c.compare_mode = 1'b0;
    c.threshold_one = '0;
    c.threshold_two = '0;
    c.delay_mode = DLY_OFF;
    c.period_ms = MS_PER_S;
    c.delay_time = '0;
    return c;
  endfunction

  // Mostly small delay limits so timers actually expire; early phases pin extremes.
  function automatic cfg_t random_setup(input int p);
    cfg_t c;
    int   pick, t2;
    c.output_type = 1'($urandom_range(0, 1));
    c.normally_open = 1'($urandom_range(0, 1));
    c.compare_mode = 1'($urandom_range(0, 1));
    c.threshold_one = THR_W'($urandom);
    t2 = int'(c.threshold_one) + int'($urandom_range(0, 80)) - 40;
    if (t2 < 0) t2 = 0;
    if (t2 > 65535) t2 = 65535;
    c.threshold_two = $urandom_range(0, 1) ? THR_W'(t2) : THR_W'($urandom);
    case (p)
      0: begin
        c.compare_mode = 1'b1;
        c.threshold_one = '0;
        c.threshold_two = '1;
      end
      5: begin
        c.threshold_one = '1;
        c.threshold_two = '1;
      end
      6: begin
        c.compare_mode = 1'b0;
        c.threshold_one = '1;
      end
      default: ;
    endcase
    c.delay_mode = (p < 8) ? MODE_W'(p) : MODE_W'($urandom_range(0, 7));
    case (p)
      1: c.period_ms = '0;
      2: c.period_ms = PER_W'(1);
      3: c.period_ms = '1;
      4: c.period_ms = MS_PER_S;
      default: begin
        pick = $urandom_range(0, 9);
        if (pick == 0) c.period_ms = '0;
        else if (pick == 1) c.period_ms = PER_W'($urandom_range(1001, 1023));
        else if (pick == 2) c.period_ms = PER_W'($urandom_range(1, 1023));
        else c.period_ms = PER_W'(1000 / $urandom_range(1, 8));
      end
    endcase
    pick = $urandom_range(0, 9);
    if (p == 7) c.delay_time = '1;
    else if (pick == 8) c.delay_time = DLY_W'($urandom);
    else if (pick == 9) c.delay_time = '0;
    else c.delay_time = DLY_W'($urandom_range(0, 6));
    return c;
  endfunction

  // Distances clustered around the active thresholds +/- hysteresis.
  function automatic reading_t random_reading();
    reading_t r;
    int       pick, target, units, tenths, sgn;
    pick = $urandom_range(0, 9);
    if (pick == 0) r.hysteresis = HYST_W'($urandom);
    else if (pick == 1) r.hysteresis = '0;
    else r.hysteresis = HYST_W'($urandom_range(0, 4));
    if (sw_cfg.compare_mode && $urandom_range(0, 1)) target = int'(sw_cfg.threshold_two);
    else target = int'(sw_cfg.threshold_one);
    sgn = int'($urandom_range(0, 2)) - 1;
    units = target + sgn * int'(r.hysteresis) + int'($urandom_range(0, 6)) - 3;
    if (units < 0) units = 0;
    tenths = units * 10 + int'($urandom_range(0, 9));
    if (tenths > MAX_TENTHS) tenths = MAX_TENTHS;
    r.distance_tenths = DIST_W'(tenths);
    if ($urandom_range(0, 9) == 0) r.distance_tenths = DIST_W'($urandom);
    r.over_range = ($urandom_range(0, 11) == 0);
    r.short_circuit = ($urandom_range(0, 15) == 0);
    return r;
  endfunction

  //--------------------------------------------------------------------------
  // Tests
  //--------------------------------------------------------------------------

  // Single threshold at 1000 units: field extremes, over-range, short.
  task automatic test_field_extremes();
    cfg_t c;
    c = plain_setup();
    c.threshold_one = THR_W'(1000);
    configure(c, 1'b0);
    send_reading(reading(0, 0, 1'b0, 1'b0));
    send_reading(reading(MAX_TENTHS, 65535, 1'b0, 1'b0));
    send_reading(reading(5000, 65535, 1'b0, 1'b0));
    send_reading(reading(9999, 0, 1'b1, 1'b0));      // over-range forces detect low
    send_reading(reading(9999, 0, 1'b0, 1'b0));
    send_reading(reading(10009, 0, 1'b0, 1'b1));     // exactly on threshold, shorted
    send_reading(reading(10010, 0, 1'b0, 1'b0));     // recover from inactive
  endtask

  // Window with thresholds given high first, PNP normally closed.
  task automatic test_window_compare();
    cfg_t c;
    c = plain_setup();
    c.output_type = 1'b1;
    c.normally_open = 1'b0;
    c.compare_mode = 1'b1;
    c.threshold_one = THR_W'(2000);
    c.threshold_two = THR_W'(1000);
    configure(c, 1'b0);
    send_reading(reading(15000, 5, 1'b0, 1'b0));
    send_reading(reading(20040, 5, 1'b0, 1'b0));     // inside hysteresis band
    send_reading(reading(20060, 5, 1'b0, 1'b0));
    send_reading(reading(10050, 5, 1'b0, 1'b0));     // on lower edge, not inside
    send_reading(reading(10060, 5, 1'b0, 1'b0));
    send_reading(reading(9940, 5, 1'b0, 1'b0));
  endtask

  // Each timed mode with a limit of two ticks: change, then expiry.
  task automatic test_delay_modes();
    cfg_t     c;
    reading_t near, far;
    near = reading(1000, 0, 1'b0, 1'b0);
    far = reading(9000, 0, 1'b0, 1'b0);
    c = plain_setup();
    c.threshold_one = THR_W'(500);
    c.period_ms = PER_W'(500);
    c.delay_time = DLY_W'(1);
    c.delay_mode = DLY_ON;
    configure(c, 1'b0);
    send_reading(near);
    send_reading(near);
    c.delay_mode = DLY_OFFD;
    configure(c, 1'b0);
    send_reading(far);
    send_reading(far);
    c.delay_mode = DLY_ON_OFF;
    configure(c, 1'b0);
    send_reading(near);
    send_reading(near);
    c.delay_mode = DLY_PULSE;
    configure(c, 1'b0);
    send_reading(far);
    send_reading(far);
  endtask

  // Frozen timing stage: detect moves, output and short are ignored.
  task automatic test_period_zero_and_short();
    cfg_t c;
    c = plain_setup();
    c.threshold_one = THR_W'(500);
    c.period_ms = '0;
    configure(c, 1'b0);
    send_reading(reading(1000, 0, 1'b0, 1'b0));
    send_reading(reading(9000, 0, 1'b0, 1'b1));
  endtask

  task automatic test_random_phases();
    int p, i;
    for (p = 0; p < PHASES; p++) begin
      fast_lane = 1'b0;
      configure(random_setup(p), (p % 4) == 0);
      fast_lane = ($urandom_range(0, 3) == 0);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        // hold off once mid-phase until the pipe is empty
        if (p == 9 && i == PHASE_ITEMS / 2) drain_results();
        send_reading(random_reading());
      end
    end
    fast_lane = 1'b0;
  endtask

  initial begin
    sw_cfg = plain_setup();
    sw_cfg.period_ms = PER_W'(1);  // reset value of the period register
    det_q = 1'b0;
    out_q = ST_OFF;
    dly_cnt = '0;
    npn_q = 1'b0;
    pnp_q = 1'b0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_field_extremes();
    test_window_compare();
    test_delay_modes();
    test_period_zero_and_short();
    test_random_phases();

    drain_results();
    repeat (60) @(posedge clk);  // catch any stray result after the last expected one
    if (fail_count == 0 && pending_levels.size() == 0) begin
      $display("sensor_switch_output_with_delay_tb OK");
    end else begin
      $display("sensor_switch_output_with_delay_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/ssod_pkg.sv
rtl/ssod_alu.sv
rtl/ssod_seq.sv
rtl/ssod_eval.sv
rtl/sensor_switch_output_with_delay.sv
sim/sensor_switch_output_with_delay_tb.sv
